>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication that must hold on every clocked cycle out of reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/snt_pkg.sv
// Package for the nearest-timestamp sample buffer.
// Field widths, stream packing and mode codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package snt_pkg;

  localparam int TIME_W   = 48;
  localparam int PAY_W    = 32;
  localparam int SENSOR_W = 3;

  // Stream data widths, padded to whole bytes.
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 88;

  // Request kinds carried in tuser.
  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [SENSOR_W-1:0] TRIGGER_RESET = 3'd6;

endpackage

`default_nettype wire

>>> hw/rtl/sensor_nearest_timestamp_buffer.sv
// Nearest-timestamp sample buffer: one ring of (time, handle) per sensor in a shared RAM.
// Depends on snt_pkg.
//
//  channel | dir | fields
//  s_axis  | in  | tuser: mode; tdata: sensor_type, time_stamp, payload
//  m_axis  | out | tuser: found; tdata: match_time, match_payload,
//          |     |        capture_started_now, evicted_oldest
//  cfg     | in  | trigger_sensor (write enable + data)
//
// Store: one RAM write (ST_STORE), then the result goes to the output register.
// Query: entries scanned oldest first (1..RING_DEPTH of them) on one RAM read port,
//   each entry through a read state (ST_RD) and a compare state (ST_CMP).
// Empty ring or unknown sensor: no RAM access. A stalled output result holds the input.
// One request in flight; the next is taken once the result sits in the output register.
// Reset clears ring heads, counts and the capture flag; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sensor_nearest_timestamp_buffer #(
  parameter int RING_DEPTH   = 64,
  parameter int SENSOR_COUNT = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] sensor_type, [50:3] time_stamp, [82:51] payload, [87:83] zero
  input  wire logic [snt_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [0] mode
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [47:0] match_time, [79:48] match_payload, [80] capture_started_now,
  // [81] evicted_oldest, [87:82] zero
  output logic [snt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] found
  output logic                               m_axis_tuser,
  input  wire logic                          cfg_we,
  input  wire logic [snt_pkg::SENSOR_W-1:0]  cfg_wdata
);

  localparam int DW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW        = $clog2(RING_DEPTH + 1);
  localparam int SIW       = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int MEM_DEPTH = SENSOR_COUNT * RING_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int TW        = snt_pkg::TIME_W;
  localparam int PW        = snt_pkg::PAY_W;
  localparam int MW        = TW + PW;

  typedef enum logic [2:0] {ST_IDLE, ST_STORE, ST_RD, ST_CMP, ST_OUT} state_t;

  state_t state;

  logic [snt_pkg::SENSOR_W-1:0] trigger_sensor;
  logic                         capture_started;

  logic [DW-1:0] ring_heads  [SENSOR_COUNT];
  logic [CW-1:0] ring_counts [SENSOR_COUNT];

  // request latched at accept
  logic [snt_pkg::SENSOR_W-1:0] sensor_q;
  logic [SIW-1:0]               sidx_q;
  logic [TW-1:0]                t_q;
  logic [PW-1:0]                pay_q;
  logic [DW-1:0]                head_q;
  logic [CW-1:0]                cnt_q;
  logic [AW-1:0]                base_q;

  // scan state
  logic [CW-1:0] idx;
  logic [DW-1:0] slot;
  logic [TW-1:0] prev_time;
  logic [PW-1:0] prev_pay;

  // result waiting for the output register
  logic          res_found;
  logic [TW-1:0] res_time;
  logic [PW-1:0] res_pay;
  logic          res_started;
  logic          res_evicted;

  logic [MW-1:0] mem [MEM_DEPTH];
  logic [MW-1:0] mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_addr;

  logic [snt_pkg::SENSOR_W-1:0] in_sensor;
  logic [TW-1:0]                in_time;
  logic [PW-1:0]                in_pay;
  logic                         in_range;
  logic [SIW-1:0]               in_sidx;
  logic                         accept;

  assign in_sensor = s_axis_tdata[snt_pkg::SENSOR_W-1:0];
  assign in_time   = s_axis_tdata[snt_pkg::SENSOR_W +: TW];
  assign in_pay    = s_axis_tdata[snt_pkg::SENSOR_W + TW +: PW];
  assign in_range  = (32'(in_sensor) < 32'(SENSOR_COUNT));
  assign in_sidx   = SIW'(in_sensor);

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // store slot: drop oldest on a full ring, then append after the newest
  logic          evict;
  logic [DW-1:0] head_inc;
  logic [DW-1:0] new_head;
  logic [CW-1:0] new_cnt;
  logic [DW:0]   wsum;
  logic [DW-1:0] wslot;

  assign evict    = (cnt_q == CW'(RING_DEPTH));
  assign head_inc = (head_q == DW'(RING_DEPTH - 1)) ? '0 : head_q + DW'(1);
  assign new_head = evict ? head_inc : head_q;
  assign new_cnt  = evict ? CW'(RING_DEPTH - 1) : cnt_q;
  assign wsum     = {1'b0, new_head} + (DW + 1)'(new_cnt);
  assign wslot    = (wsum >= (DW + 1)'(RING_DEPTH)) ? DW'(wsum - (DW + 1)'(RING_DEPTH))
                                                    : DW'(wsum);

  // scan compare
  logic [TW-1:0] cur_time;
  logic [PW-1:0] cur_pay;
  logic [TW-1:0] dist_after;
  logic [TW-1:0] dist_before;
  logic [DW-1:0] slot_inc;

  assign cur_time    = mem_rdata[TW-1:0];
  assign cur_pay     = mem_rdata[TW +: PW];
  assign dist_after  = cur_time - t_q;
  assign dist_before = t_q - prev_time;
  assign slot_inc    = (slot == DW'(RING_DEPTH - 1)) ? '0 : slot + DW'(1);

  assign mem_we   = (state == ST_STORE);
  assign mem_addr = base_q + AW'(mem_we ? wslot : slot);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {pay_q, t_q};
    end
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      trigger_sensor  <= snt_pkg::TRIGGER_RESET;
      capture_started <= 1'b0;
      m_axis_tvalid   <= 1'b0;
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        ring_heads[k]  <= '0;
        ring_counts[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        trigger_sensor <= cfg_wdata;
      end
      // ST_OUT owns the valid flag in its own cycle
      if (m_axis_tvalid && m_axis_tready && state != ST_OUT) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            sensor_q    <= in_sensor;
            sidx_q      <= in_sidx;
            t_q         <= in_time;
            pay_q       <= in_pay;
            head_q      <= ring_heads[in_sidx];
            cnt_q       <= ring_counts[in_sidx];
            base_q      <= AW'(in_sidx) * AW'(RING_DEPTH);
            slot        <= ring_heads[in_sidx];
            idx         <= '0;
            res_found   <= 1'b0;
            res_time    <= '0;
            res_pay     <= '0;
            res_started <= 1'b0;
            res_evicted <= 1'b0;
            if (!in_range) begin
              state <= ST_OUT;
            end else if (s_axis_tuser == snt_pkg::MODE_STORE) begin
              state <= ST_STORE;
            end else if (ring_counts[in_sidx] == '0) begin
              state <= ST_OUT;
            end else begin
              state <= ST_RD;
            end
          end
        end

        ST_STORE: begin
          if (!capture_started && sensor_q == trigger_sensor) begin
            capture_started <= 1'b1;
            res_started     <= 1'b1;
          end
          res_evicted         <= evict;
          ring_heads[sidx_q]  <= new_head;
          ring_counts[sidx_q] <= new_cnt + CW'(1);
          state               <= ST_OUT;
        end

        ST_RD: begin
          state <= ST_CMP;
        end

        ST_CMP: begin
          if (cur_time >= t_q) begin
            res_found <= 1'b1;
            if (idx != '0 && !(dist_after < dist_before)) begin
              res_time <= prev_time;
              res_pay  <= prev_pay;
            end else begin
              res_time <= cur_time;
              res_pay  <= cur_pay;
            end
            state <= ST_OUT;
          end else if (idx == cnt_q - CW'(1)) begin
            // all entries earlier: keep only the newest
            res_found           <= 1'b1;
            res_time            <= cur_time;
            res_pay             <= cur_pay;
            ring_heads[sidx_q]  <= slot;
            ring_counts[sidx_q] <= CW'(1);
            state               <= ST_OUT;
          end else begin
            prev_time <= cur_time;
            prev_pay  <= cur_pay;
            idx       <= idx + CW'(1);
            slot      <= slot_inc;
            state     <= ST_RD;
          end
        end

        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_found;
            m_axis_tdata  <= {6'd0, res_evicted, res_started, res_pay, res_time};
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/snt_checker.sv
// Port-level checker for the nearest-timestamp sample buffer, bound to the top level.
// Depends on snt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module snt_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [snt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tuser
);

  logic                            stall;
  logic                            out_hit;
  logic                            out_miss;
  logic [snt_pkg::OUT_DATA_W:0]    out_word;

  assign stall    = m_axis_tvalid && !m_axis_tready;
  assign out_hit  = m_axis_tvalid && m_axis_tuser;
  assign out_miss = m_axis_tvalid && !m_axis_tuser;
  assign out_word = {m_axis_tuser, m_axis_tdata};

  `ASSERT_IMPL(a_out_hold_valid, clk, rst, stall, ##1 m_axis_tvalid, "result dropped in stall")
  `ASSERT_IMPL(a_out_hold_data, clk, rst, stall, ##1 $stable(out_word), "result changed in stall")
  `ASSERT_IMPL(a_miss_zero, clk, rst, out_miss, m_axis_tdata[79:0] == 80'd0, "miss carries a match")
  `ASSERT_IMPL(a_hit_no_flags, clk, rst, out_hit, m_axis_tdata[81:80] == 2'd0, "query has store flags")

endmodule

bind sensor_nearest_timestamp_buffer snt_checker u_snt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> tb/tb_sensor_nearest_timestamp_buffer.sv
// Self-checking bench for sensor_nearest_timestamp_buffer: directed table, then random stores/queries.
// Behavior is predicted in-bench per sensor ring; depends on snt_pkg and the block.
`timescale 1ns / 1ps

module tb_sensor_nearest_timestamp_buffer;

  localparam int DEPTH    = 64;
  localparam int SENSORS  = 8;
  localparam int EXP_SIZE = 4096;
  localparam int ROW_MAX  = 32;

  typedef struct packed {
    logic                       found;
    logic [snt_pkg::TIME_W-1:0] mtime;
    logic [snt_pkg::PAY_W-1:0]  mpay;
    logic                       started;
    logic                       evicted;
  } match_t;

  typedef struct packed {
    logic                         typed;
    logic                         mode;
    logic [snt_pkg::SENSOR_W-1:0] sensor;
    logic [snt_pkg::TIME_W-1:0]   ts;
    logic [snt_pkg::PAY_W-1:0]    pay;
    match_t                       want;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [snt_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [snt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [snt_pkg::SENSOR_W-1:0] cfg_wdata = '0;

  sensor_nearest_timestamp_buffer #(.RING_DEPTH(DEPTH), .SENSOR_COUNT(SENSORS)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the rings
  logic [snt_pkg::TIME_W-1:0]   ring_time [SENSORS][DEPTH];
  logic [snt_pkg::PAY_W-1:0]    ring_pay  [SENSORS][DEPTH];
  int unsigned                  ring_head [SENSORS];
  int unsigned                  ring_cnt  [SENSORS];
  logic                         cap_started;
  logic [snt_pkg::TIME_W-1:0]   cap_time;
  logic [snt_pkg::SENSOR_W-1:0] trig_sensor;
  logic [snt_pkg::TIME_W-1:0]   last_ts [SENSORS];

  // expected results in request order
  match_t   exp_list [EXP_SIZE];
  int       exp_wr = 0;
  int       exp_rd = 0;
  request_t directed_rows [ROW_MAX];
  int       row_cnt = 0;
  int       errors = 0;
  bit       steady_ready = 0;

  function automatic match_t nearest_lookup(input logic mode,
                                            input logic [snt_pkg::SENSOR_W-1:0] s,
                                            input logic [snt_pkg::TIME_W-1:0] t,
                                            input logic [snt_pkg::PAY_W-1:0] p);
    match_t r;
    int unsigned h, c, i, pick, a, b;
    logic [snt_pkg::TIME_W-1:0] da, db;
    r = '0;
    h = ring_head[s];
    c = ring_cnt[s];
    if (mode == snt_pkg::MODE_STORE) begin
      if (!cap_started && s == trig_sensor) begin
        cap_started = 1'b1;
        cap_time = t;
        r.started = 1'b1;
      end
      if (c >= DEPTH) begin
        h = (h + 1) % DEPTH;
        c = DEPTH - 1;
        r.evicted = 1'b1;
      end
      ring_time[s][(h + c) % DEPTH] = t;
      ring_pay[s][(h + c) % DEPTH] = p;
      ring_head[s] = h;
      ring_cnt[s] = c + 1;
    end else if (c > 0) begin
      i = 0;
      while (i < c && ring_time[s][(h + i) % DEPTH] < t) i++;
      if (i == c) begin
        // everything older than the query: keep only the newest
        pick = (h + c - 1) % DEPTH;
        ring_head[s] = pick;
        ring_cnt[s] = 1;
      end else if (i == 0) begin
        pick = h;
      end else begin
        a = (h + i) % DEPTH;
        b = (h + i - 1) % DEPTH;
        da = ring_time[s][a] - t;
        db = t - ring_time[s][b];
        pick = (da < db) ? a : b;
      end
      r.found = 1'b1;
      r.mtime = ring_time[s][pick];
      r.mpay = ring_pay[s][pick];
    end
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input request_t rq);
    match_t m;
    int g;
    g = steady_ready ? 0 : gap_len();
    if (g > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = rq.mode;
    s_axis_tdata = {5'b0, rq.pay, rq.ts, rq.sensor};
    do @(posedge clk); while (!s_axis_tready);
    m = nearest_lookup(rq.mode, rq.sensor, rq.ts, rq.pay);
    exp_list[exp_wr] = rq.typed ? rq.want : m;
    exp_wr++;
  endtask

  task automatic add_row(input logic mode, input logic [2:0] s, input logic [47:0] t,
                         input logic [31:0] p, input logic typed, input match_t want);
    request_t rq;
    rq.typed = typed; rq.mode = mode; rq.sensor = s; rq.ts = t; rq.pay = p; rq.want = want;
    directed_rows[row_cnt] = rq;
    row_cnt++;
  endtask

  task automatic drain_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait (exp_rd == exp_wr);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_trigger(input logic [snt_pkg::SENSOR_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    trig_sensor = v;
  endtask

  // Random request; hot sensor concentrates traffic so rings fill and evict.
  function automatic request_t random_request(input int hot);
    request_t rq;
    int k;
    rq = '0;
    rq.mode = ($urandom_range(0, 99) < 22) ? snt_pkg::MODE_QUERY : snt_pkg::MODE_STORE;
    rq.sensor = ($urandom_range(0, 99) < 60) ? hot[2:0] : 3'($urandom_range(0, 7));
    rq.pay = $urandom;
    if (rq.mode == snt_pkg::MODE_STORE) begin
      if ($urandom_range(0, 99) < 4)
        last_ts[rq.sensor] = {16'($urandom), 32'($urandom)};
      else
        last_ts[rq.sensor] = last_ts[rq.sensor] + 48'($urandom_range(0, 20));
      rq.ts = last_ts[rq.sensor];
    end else begin
      k = $urandom_range(0, 9);
      case (k)
        0: rq.ts = {16'($urandom), 32'($urandom)};
        1: rq.ts = last_ts[rq.sensor] + 48'($urandom_range(1, 50));
        2: rq.ts = '0;
        default: rq.ts = last_ts[rq.sensor] - 48'($urandom_range(0, 600));
      endcase
    end
    return rq;
  endfunction

  // Sink side back-pressure
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = steady_ready ? 0 : gap_len();
      if (n > 0) begin
        m_axis_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    match_t exp_m, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.found = m_axis_tuser;
      got.mtime = m_axis_tdata[47:0];
      got.mpay = m_axis_tdata[79:48];
      got.started = m_axis_tdata[80];
      got.evicted = m_axis_tdata[81];
      if (exp_rd == exp_wr) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_m = exp_list[exp_rd];
        exp_rd++;
        if (got.found !== exp_m.found) begin
          $display("%0t: found exp %b got %b", $time, exp_m.found, got.found);
          errors++;
        end
        if (got.mtime !== exp_m.mtime) begin
          $display("%0t: match_time exp %h got %h", $time, exp_m.mtime, got.mtime);
          errors++;
        end
        if (got.mpay !== exp_m.mpay) begin
          $display("%0t: match_payload exp %h got %h", $time, exp_m.mpay, got.mpay);
          errors++;
        end
        if (got.started !== exp_m.started) begin
          $display("%0t: capture_started_now exp %b got %b", $time, exp_m.started,
                   got.started);
          errors++;
        end
        if (got.evicted !== exp_m.evicted) begin
          $display("%0t: evicted_oldest exp %b got %b", $time, exp_m.evicted, got.evicted);
          errors++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("sensor_nearest_timestamp_buffer verification failed");
    $finish;
  end

  initial begin
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
    localparam logic Q = snt_pkg::MODE_QUERY;
    localparam logic W = snt_pkg::MODE_STORE;
    int phase, n, hot, guard;
    for (int s = 0; s < SENSORS; s++) begin
      ring_head[s] = 0;
      ring_cnt[s] = 0;
      last_ts[s] = {16'($urandom), 32'($urandom)};
    end
    cap_started = 1'b0;
    cap_time = '0;
    trig_sensor = snt_pkg::TRIGGER_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // mode, sensor, time, payload, typed, expected {found, time, payload, started, evicted}
    add_row(Q, 3'd1, 48'd0, 32'h1234, 1'b1, '0);                         // empty ring
    add_row(W, 3'd6, 48'd100, 32'hA, 1'b1, {1'b0, 48'd0, 32'd0, 1'b1, 1'b0});
    add_row(W, 3'd6, 48'd200, 32'hB, 1'b1, '0);                          // no second latch
    add_row(W, 3'd1, 48'd1000, 32'd11, 1'b1, '0);
    add_row(W, 3'd1, 48'd2000, 32'd22, 1'b1, '0);
    add_row(W, 3'd1, 48'd3000, 32'd33, 1'b1, '0);
    add_row(Q, 3'd1, 48'd1500, 32'd0, 1'b1, {1'b1, 48'd1000, 32'd11, 2'b0}); // tie -> earlier
    add_row(Q, 3'd1, 48'd1501, 32'd0, 1'b1, {1'b1, 48'd2000, 32'd22, 2'b0});
    add_row(Q, 3'd1, 48'd500, 32'd0, 1'b1, {1'b1, 48'd1000, 32'd11, 2'b0});  // before all
    add_row(Q, 3'd1, 48'd1000, 32'd0, 1'b1, {1'b1, 48'd1000, 32'd11, 2'b0});
    add_row(Q, 3'd1, 48'd5000, 32'd0, 1'b1, {1'b1, 48'd3000, 32'd33, 2'b0}); // after all
    add_row(Q, 3'd1, 48'd0, 32'd0, 1'b1, {1'b1, 48'd3000, 32'd33, 2'b0});    // ring collapsed
    add_row(W, 3'd7, TMAX, 32'hFFFF_FFFF, 1'b1, '0);
    add_row(Q, 3'd7, TMAX, 32'd0, 1'b1, {1'b1, TMAX, 32'hFFFF_FFFF, 2'b0});
    add_row(Q, 3'd7, 48'd0, 32'hFFFF_FFFF, 1'b1, {1'b1, TMAX, 32'hFFFF_FFFF, 2'b0});
    add_row(W, 3'd0, 48'd0, 32'd0, 1'b1, '0);
    add_row(Q, 3'd0, 48'd0, 32'd0, 1'b1, {1'b1, 48'd0, 32'd0, 2'b0});
    add_row(W, 3'd3, 48'd50, 32'h55, 1'b0, '0);
    add_row(W, 3'd3, 48'd10, 32'h66, 1'b0, '0);                          // out of order
    add_row(Q, 3'd3, 48'd20, 32'd0, 1'b0, '0);
    add_row(Q, 3'd3, 48'd60, 32'd0, 1'b0, '0);
    for (int i = 0; i < row_cnt; i++) send(directed_rows[i]);
    drain_idle();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_trigger(3'd0);
        1: write_trigger(3'd7);
        2: write_trigger(3'($urandom_range(1, 6)));
        default: write_trigger(snt_pkg::TRIGGER_RESET);
      endcase
      steady_ready = (phase == 2);
      hot = $urandom_range(0, 7);
      for (n = 0; n < 400; n++) begin
        if (n % 100 == 0) hot = $urandom_range(0, 7);
        send(random_request(hot));
      end
      drain_idle();
    end

    guard = 0;
    while (exp_rd != exp_wr && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && exp_rd == exp_wr)
      $display("sensor_nearest_timestamp_buffer verification clean");
    else
      $display("sensor_nearest_timestamp_buffer verification failed");
    $finish;
  end

endmodule
